[rtl/bfpa_pkg.sv]
// ----------------------------------------------------------------------------
// bfpa_pkg
// Shared types and codes of the best-fit partition allocator.
// ----------------------------------------------------------------------------
package bfpa_pkg;

  localparam int CMD_W    = 2;
  localparam int REQ_W    = 16;
  localparam int PART_W   = 4;
  localparam int STATUS_W = 2;
  localparam int REM_W    = 16;
  localparam int CNT_W    = 5;

  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FIT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [REQ_W-1:0]  request_size;
    logic [PART_W-1:0] partition;
  } cmd_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PART_W-1:0]   granted_partition;
    logic [REM_W-1:0]    remaining_after;
  } result_t;

  // Control of the best-fit tracker: clear starts a new search, sample takes
  // one entry that the memory has just returned.
  typedef struct packed {
    logic clear;
    logic sample;
  } scan_ctl_t;

endpackage

[rtl/bfpa_ram.sv]
// ----------------------------------------------------------------------------
// bfpa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bfpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/bfpa_scan.sv]
// ----------------------------------------------------------------------------
// bfpa_scan
// Best-fit tracker: keeps the smallest fitting free size seen in a search.
// ----------------------------------------------------------------------------
module bfpa_scan
  import bfpa_pkg::*;
#(
  parameter int SIZE_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  scan_ctl_t            ctl_i,
  input  logic [CNT_W-1:0]     idx_i,
  input  logic [SIZE_BITS-1:0] data_i,
  input  logic [REQ_W-1:0]     req_i,
  output logic                 found_o,
  output logic [CNT_W-1:0]     best_idx_o,
  output logic [SIZE_BITS-1:0] best_val_o
);

  localparam int CW = (SIZE_BITS > REQ_W) ? SIZE_BITS : REQ_W;

  logic                 found_q, found_d;
  logic [CNT_W-1:0]     best_idx_q;
  logic [SIZE_BITS-1:0] best_val_q;
  logic                 take;

  // Strict less-than keeps the lower index on a tie.
  assign take = ctl_i.sample && (CW'(data_i) >= CW'(req_i)) &&
                (!found_q || (data_i < best_val_q));

  always_comb begin
    found_d = found_q;
    if (ctl_i.clear) begin
      found_d = 1'b0;
    end else if (take) begin
      found_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_idx_q <= idx_i;
      best_val_q <= data_i;
    end
  end

  assign found_o    = found_q;
  assign best_idx_o = best_idx_q;
  assign best_val_o = best_val_q;

endmodule

[rtl/best_fit_partition_allocator.sv]
// ----------------------------------------------------------------------------
// best_fit_partition_allocator
// Best-fit allocator over a set of partitions whose free sizes live in a RAM.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its one result is on
// result_o for a single cycle with result_valid_o high and cannot be held off.
// A load writes its entry directly; a release reads, then writes back. An
// allocate reads every partition in use through the single RAM read port and
// then writes the chosen one back, if one fits. Out-of-range loads and
// releases, the unused command and an allocate with no partitions in use answer
// without leaving the idle state. After reset the block clears the RAM, one
// entry a cycle, and stays busy until every entry is cleared.
module best_fit_partition_allocator
  import bfpa_pkg::*;
#(
  parameter int NUM_PARTITIONS = 16,
  parameter int SIZE_BITS      = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  cmd_item_t        item_i,
  output logic             result_valid_o,
  output result_t          result_o,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i
);

  localparam int AW  = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
  localparam int CW  = (SIZE_BITS > REQ_W) ? SIZE_BITS : REQ_W;
  localparam int SW  = CW + 1;
  localparam int NW  = $clog2(NUM_PARTITIONS + 1);
  localparam int NCW = (NW > CNT_W) ? NW : CNT_W;
  localparam logic [SIZE_BITS-1:0] SizeMax = '1;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_RMW    = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [REQ_W-1:0]  req_q;
  logic [PART_W-1:0] part_q;
  logic             res_valid_q, res_valid_d;
  result_t          res_q, res_d;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [SIZE_BITS-1:0] ram_wdata, ram_rdata;

  scan_ctl_t            scan_ctl;
  logic                 found;
  logic [CNT_W-1:0]     best_idx;
  logic [SIZE_BITS-1:0] best_val;

  logic [CNT_W-1:0]     n_eff;
  logic                 accept;
  logic                 in_range;
  logic [SIZE_BITS-1:0] load_val;
  logic [SW-1:0]        rel_sum;
  logic [SIZE_BITS-1:0] rel_val;
  logic [SIZE_BITS-1:0] alloc_val;

  // A count above the store acts as the store size.
  assign n_eff = (NCW'(count_q) > NCW'(NUM_PARTITIONS)) ? CNT_W'(NUM_PARTITIONS) : count_q;

  assign accept   = start && !busy;
  assign in_range = CNT_W'(item_i.partition) < n_eff;
  assign load_val = (CW'(item_i.request_size) > CW'(SizeMax)) ?
                    SizeMax : SIZE_BITS'(item_i.request_size);
  assign rel_sum  = SW'(ram_rdata) + SW'(req_q);
  assign rel_val  = (rel_sum > SW'(SizeMax)) ? SizeMax : SIZE_BITS'(rel_sum);
  assign alloc_val = best_val - SIZE_BITS'(req_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = AW'(part_q);
    ram_wdata   = rel_val;
    ram_raddr   = AW'(item_i.partition);
    scan_ctl    = '0;

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(NUM_PARTITIONS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_d.granted_partition = item_i.partition;
          res_d.remaining_after   = '0;
          res_d.status            = STATUS_OK;
          case (item_i.cmd)
            CMD_LOAD: begin
              res_valid_d = 1'b1;
              if (in_range) begin
                ram_we    = 1'b1;
                ram_waddr = AW'(item_i.partition);
                ram_wdata = load_val;
                res_d.remaining_after = REM_W'(load_val);
              end else begin
                res_d.status = STATUS_RANGE;
              end
            end
            CMD_RELEASE: begin
              if (in_range) begin
                state_d = S_RMW;
              end else begin
                res_valid_d  = 1'b1;
                res_d.status = STATUS_RANGE;
              end
            end
            CMD_ALLOC: begin
              if (n_eff == '0) begin
                res_valid_d             = 1'b1;
                res_d.status            = STATUS_NO_FIT;
                res_d.granted_partition = '0;
              end else begin
                scan_ctl.clear = 1'b1;
                ram_raddr      = '0;
                cnt_d          = CNT_W'(1);
                state_d        = S_SCAN;
              end
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_RMW: begin
        ram_we                = 1'b1;
        res_valid_d           = 1'b1;
        res_d.status          = STATUS_OK;
        res_d.remaining_after = REM_W'(rel_val);
        state_d               = S_IDLE;
      end
      S_SCAN: begin
        // The RAM returns the entry whose read was issued in the previous cycle.
        scan_ctl.sample = 1'b1;
        if (cnt_q < n_eff) begin
          ram_raddr = AW'(cnt_q);
          cnt_d     = cnt_q + CNT_W'(1);
        end else begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
        if (found) begin
          ram_we                  = 1'b1;
          ram_waddr               = AW'(best_idx);
          ram_wdata               = alloc_val;
          res_d.status            = STATUS_OK;
          res_d.granted_partition = PART_W'(best_idx);
          res_d.remaining_after   = REM_W'(alloc_val);
        end else begin
          res_d.status            = STATUS_NO_FIT;
          res_d.granted_partition = '0;
          res_d.remaining_after   = '0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      count_q     <= '0;
      cnt_q       <= '0;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      req_q  <= item_i.request_size;
      part_q <= item_i.partition;
    end
  end

  bfpa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (NUM_PARTITIONS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bfpa_scan #(
    .SIZE_BITS (SIZE_BITS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (scan_ctl),
    .idx_i      (cnt_q - CNT_W'(1)),
    .data_i     (ram_rdata),
    .req_i      (req_q),
    .found_o    (found),
    .best_idx_o (best_idx),
    .best_val_o (best_val)
  );

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // A read-modify-write always ends in a result transfer.
  a_rmw_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RMW || state_q == S_COMMIT) |=> res_valid_q)
    else $error("read-modify-write without a result");

  // No result comes out of the clearing pass.
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !res_valid_q)
    else $error("result during clearing pass");

  // A granted allocation never reports a partition outside the count in use.
  a_grant_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT && found) |-> (best_idx < n_eff))
    else $error("granted partition beyond count");

  // The scan never addresses past the partitions in use.
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (cnt_q <= n_eff && cnt_q != '0))
    else $error("scan counter out of bounds");

endmodule
